/* rtl/core/assert_macros.svh */
// Assertion macros shared by the box blur RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBC_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("box blur assertion failed");

// Next-cycle implication, disabled during reset.
`define BBC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("box blur assertion failed");

`endif

/* rtl/core/bbc_pkg.sv */
// Shared types and constants of the box blur block.
`timescale 1ns / 1ps
package bbc_pkg;
  localparam int NCH = 4;
  localparam int PIX_W = 8;
  localparam int ROW_W = 12;
  localparam int COL_W = 12;
  localparam int SLOT_W = 5;
  localparam int DIM_W = 13;
  localparam int IDX_W = 25;
  localparam int RAD_W = 3;
  localparam int SIDE_W = 4;
  localparam int AREA_W = 8;
  localparam int SUM_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL   = 2'd0,
    REG_WIDTH    = 2'd1,
    REG_HEIGHT   = 2'd2,
    REG_CHANNELS = 2'd3
  } cfg_reg_t;

  typedef logic [NCH-1:0][PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [RAD_W-1:0] r;
    logic [2:0]       nch;
    logic [IDX_W-1:0] total;
    logic [IDX_W-1:0] lag;
  } geom_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
    pix_t              data;
  } store_wr_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } job_t;

  typedef struct packed {
    pix_t chan;
    logic frame_end;
  } result_t;
endpackage

/* rtl/core/bbc_fifo.sv */
// Small register queue used between the blur stages and at the result side.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbc_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `BBC_ASSERT_IMPL(a_fifo_push_room, clk, rst, push, !full || pop)
  `BBC_ASSERT_IMPL(a_fifo_pop_data, clk, rst, pop, !empty)
endmodule

/* rtl/core/bbc_front.sv */
// Front stage: writes pixels into the line store and decides when an output is due.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbc_front #(
  parameter int ROWS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  bbc_pkg::geom_t     geom,
  input  logic               restart,
  input  logic               accept,
  input  logic               mode,
  input  bbc_pkg::pix_t      pix,
  output bbc_pkg::store_wr_t wr,
  output logic               job_push,
  output bbc_pkg::job_t      job
);
  logic [bbc_pkg::COL_W-1:0]  in_col;
  logic [bbc_pkg::ROW_W-1:0]  in_row;
  logic [bbc_pkg::SLOT_W-1:0] in_slot;
  logic [bbc_pkg::IDX_W-1:0]  in_idx;
  logic [bbc_pkg::COL_W-1:0]  out_col;
  logic [bbc_pkg::ROW_W-1:0]  out_row;
  logic [bbc_pkg::SLOT_W-1:0] out_slot;
  logic [bbc_pkg::IDX_W-1:0]  out_idx;

  logic                       done;
  logic                       take;
  logic                       last;
  logic [bbc_pkg::IDX_W-1:0]  written;
  logic [bbc_pkg::IDX_W-1:0]  need;
  logic [bbc_pkg::IDX_W-1:0]  need_cap;
  logic                       in_col_end;
  logic                       out_col_end;

  always_comb begin
    done     = (in_idx >= geom.total);
    take     = accept && !done && !mode;
    written  = in_idx + bbc_pkg::IDX_W'(take);
    need     = out_idx + geom.lag + bbc_pkg::IDX_W'(1);
    need_cap = (need > geom.total) ? geom.total : need;
    last     = (out_idx == geom.total - bbc_pkg::IDX_W'(1));
    job_push = accept && (take || done) && (written >= need_cap);
    in_col_end  = ((bbc_pkg::DIM_W'(in_col) + bbc_pkg::DIM_W'(1)) == geom.w);
    out_col_end = ((bbc_pkg::DIM_W'(out_col) + bbc_pkg::DIM_W'(1)) == geom.w);
    wr.en    = take;
    wr.slot  = in_slot;
    wr.col   = in_col;
    wr.data  = pix;
    job.row  = out_row;
    job.col  = out_col;
    job.slot = out_slot;
    job.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst || restart || (job_push && last)) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      in_idx   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
      out_idx  <= '0;
    end else begin
      if (take) begin
        in_idx <= in_idx + bbc_pkg::IDX_W'(1);
        if (in_col_end) begin
          in_col  <= '0;
          in_row  <= in_row + bbc_pkg::ROW_W'(1);
          in_slot <= (in_slot == bbc_pkg::SLOT_W'(ROWS - 1)) ? '0
                     : in_slot + bbc_pkg::SLOT_W'(1);
        end else begin
          in_col <= in_col + bbc_pkg::COL_W'(1);
        end
      end
      if (job_push) begin
        out_idx <= out_idx + bbc_pkg::IDX_W'(1);
        if (out_col_end) begin
          out_col  <= '0;
          out_row  <= out_row + bbc_pkg::ROW_W'(1);
          out_slot <= (out_slot == bbc_pkg::SLOT_W'(ROWS - 1)) ? '0
                      : out_slot + bbc_pkg::SLOT_W'(1);
        end else begin
          out_col <= out_col + bbc_pkg::COL_W'(1);
        end
      end
    end
  end

  `BBC_ASSERT_IMPL(a_job_on_beat, clk, rst, job_push, accept)
endmodule

/* rtl/core/bbc_back.sv */
// Back stage: line store, window accumulation and rounding division per output pixel.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbc_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int ROWS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  bbc_pkg::geom_t     geom,
  input  bbc_pkg::store_wr_t wr,
  input  logic               job_empty,
  input  bbc_pkg::job_t      job,
  output logic               job_pop,
  output logic               res_push,
  output bbc_pkg::result_t   res,
  output logic               busy
);
  localparam int MCOL_W = $clog2(MAX_WIDTH);
  localparam int MSLOT_W = $clog2(ROWS);
  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(bbc_pkg::SUM_W);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_LAST = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;

  bbc_pkg::pix_t mem [DEPTH];
  bbc_pkg::pix_t rdata;
  logic          rd_pend;

  logic [bbc_pkg::ROW_W-1:0]  jrow;
  logic [bbc_pkg::COL_W-1:0]  jcol;
  logic [bbc_pkg::SLOT_W-1:0] jslot;
  logic                       jlast;
  logic [bbc_pkg::SIDE_W-1:0] dy;
  logic [bbc_pkg::SIDE_W-1:0] dx;
  logic [CNT_W-1:0]           cnt;

  logic [bbc_pkg::NCH-1:0][bbc_pkg::SUM_W-1:0]  acc;
  logic [bbc_pkg::NCH-1:0][bbc_pkg::SUM_W-1:0]  num;
  logic [bbc_pkg::NCH-1:0][bbc_pkg::AREA_W-1:0] rem;
  logic [bbc_pkg::NCH-1:0][bbc_pkg::SUM_W-1:0]  num_next;
  logic [bbc_pkg::NCH-1:0][bbc_pkg::AREA_W-1:0] rem_next;

  logic [bbc_pkg::SIDE_W-1:0] side;
  logic [bbc_pkg::AREA_W-1:0] area;
  logic [bbc_pkg::AREA_W-1:0] half;
  logic signed [14:0]         ys;
  logic signed [14:0]         xs;
  logic signed [14:0]         dys;
  logic signed [14:0]         ss;
  logic [bbc_pkg::ROW_W-1:0]  cy;
  logic [bbc_pkg::COL_W-1:0]  cx;
  logic [MSLOT_W-1:0]         rslot;
  logic [ADDR_W-1:0]          raddr;
  logic [ADDR_W-1:0]          waddr;
  logic [bbc_pkg::AREA_W:0]   sh;
  logic                       ge;

  always_comb begin
    side = {geom.r, 1'b1};
    area = bbc_pkg::AREA_W'(side) * bbc_pkg::AREA_W'(side);
    half = (area - bbc_pkg::AREA_W'(1)) >> 1;

    ys = $signed({3'b0, jrow}) + $signed({11'b0, dy}) - $signed({12'b0, geom.r});
    if (ys < 0) begin
      cy = '0;
    end else if (ys >= $signed({2'b0, geom.h})) begin
      cy = bbc_pkg::ROW_W'(geom.h - bbc_pkg::DIM_W'(1));
    end else begin
      cy = ys[bbc_pkg::ROW_W-1:0];
    end

    xs = $signed({3'b0, jcol}) + $signed({11'b0, dx}) - $signed({12'b0, geom.r});
    if (xs < 0) begin
      cx = '0;
    end else if (xs >= $signed({2'b0, geom.w})) begin
      cx = bbc_pkg::COL_W'(geom.w - bbc_pkg::DIM_W'(1));
    end else begin
      cx = xs[bbc_pkg::COL_W-1:0];
    end

    dys = $signed({3'b0, cy}) - $signed({3'b0, jrow});
    ss  = $signed({10'b0, jslot}) + dys;
    if (ss < 0) begin
      ss = ss + 15'(ROWS);
    end else if (ss >= 15'(ROWS)) begin
      ss = ss - 15'(ROWS);
    end
    rslot = ss[MSLOT_W-1:0];
    raddr = ADDR_W'(rslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx[MCOL_W-1:0]);
    waddr = ADDR_W'(wr.slot[MSLOT_W-1:0]) * ADDR_W'(MAX_WIDTH)
            + ADDR_W'(wr.col[MCOL_W-1:0]);

    sh = '0;
    ge = 1'b0;
    for (int c = 0; c < bbc_pkg::NCH; c++) begin
      sh = {rem[c], num[c][bbc_pkg::SUM_W-1]};
      ge = (sh >= {1'b0, area});
      rem_next[c] = ge ? bbc_pkg::AREA_W'(sh - {1'b0, area}) : sh[bbc_pkg::AREA_W-1:0];
      num_next[c] = {num[c][bbc_pkg::SUM_W-2:0], ge};
    end

    for (int c = 0; c < bbc_pkg::NCH; c++) begin
      res.chan[c] = (c < int'(geom.nch)) ? num[c][bbc_pkg::PIX_W-1:0] : '0;
    end
    res.frame_end = jlast;
  end

  assign job_pop  = (state == S_IDLE) && !job_empty;
  assign res_push = (state == S_DONE);
  assign busy     = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (dx == side - bbc_pkg::SIDE_W'(1) && dy == side - bbc_pkg::SIDE_W'(1)) begin
            state <= S_LAST;
          end
        end
        S_LAST: state <= S_PREP;
        S_PREP: state <= S_DIV;
        S_DIV: begin
          if (cnt == CNT_W'(bbc_pkg::SUM_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        jrow  <= job.row;
        jcol  <= job.col;
        jslot <= job.slot;
        jlast <= job.last;
        dy    <= '0;
        dx    <= '0;
        acc   <= '0;
      end
      S_READ: begin
        if (dx == side - bbc_pkg::SIDE_W'(1)) begin
          dx <= '0;
          dy <= dy + bbc_pkg::SIDE_W'(1);
        end else begin
          dx <= dx + bbc_pkg::SIDE_W'(1);
        end
      end
      S_PREP: begin
        cnt <= '0;
        for (int c = 0; c < bbc_pkg::NCH; c++) begin
          num[c] <= acc[c] + bbc_pkg::SUM_W'(half);
          rem[c] <= '0;
        end
      end
      S_DIV: begin
        cnt <= cnt + CNT_W'(1);
        num <= num_next;
        rem <= rem_next;
      end
      default: begin
      end
    endcase
    if (rd_pend && state != S_IDLE) begin
      for (int c = 0; c < bbc_pkg::NCH; c++) begin
        acc[c] <= acc[c] + bbc_pkg::SUM_W'(rdata[c]);
      end
    end
  end

  `BBC_ASSERT_IMPL(a_store_quiet, clk, rst, wr.en, state == S_IDLE)
  `BBC_ASSERT_NEXT(a_prep_to_div, clk, rst, state == S_PREP, state == S_DIV)
endmodule

/* rtl/core/box_blur_clamped_edges.sv */
// Top level of the box blur with clamp-to-edge borders.
// Usage: pixels enter in raster order through push/full; a beat is taken when push is
// high and full is low. mode selects a pixel beat or a drain beat; after the last pixel
// of a frame, drain beats release the outputs still held back. Results leave through
// empty/pop in order; frame_end marks the last output of the frame.
// Configuration is written through cfg_valid/cfg_ready/cfg_index/cfg_data while the
// block is idle; any write restarts the frame position counters, and full stays high
// for one cycle after a write and after reset while the frame geometry settles.
// An output is released by the input beat radius rows and radius pixels later. The back
// stage then pops its job while idle, reads each pixel of the k by k window from the line
// store (k is the effective window side, 1 when passing through), finishes and rounds the
// sum in the S_LAST and S_PREP setup states, divides it and pushes the result. After a
// releasing beat, full stays high until that push; beats that release nothing leave it low.
// Reset clears all position counters and loads kernel 3, 640 x 480, three channels.
// The line store holds MAX_KERNEL+1 rows and is not cleared; only written entries are read.
// Two results can wait at the output; when the receiver stalls, full rises once both
// result slots hold results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module box_blur_clamped_edges #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_KERNEL = 15,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             mode,
  input  logic [7:0]                       chan0_in,
  input  logic [7:0]                       chan1_in,
  input  logic [7:0]                       chan2_in,
  input  logic [7:0]                       chan3_in,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       chan0_out,
  output logic [7:0]                       chan1_out,
  output logic [7:0]                       chan2_out,
  output logic [7:0]                       chan3_out,
  output logic                             frame_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int ROWS = MAX_KERNEL + 1;
  localparam int JOB_W = $bits(bbc_pkg::job_t);
  localparam int RES_W = $bits(bbc_pkg::result_t);

  logic [3:0]  win_side;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [2:0]  channel_count;

  bbc_pkg::geom_t     geom;
  bbc_pkg::store_wr_t wr;
  bbc_pkg::job_t      job_in;
  bbc_pkg::job_t      job_out;
  bbc_pkg::result_t   res_in;
  bbc_pkg::result_t   res_out;
  bbc_pkg::pix_t      pix;

  logic [bbc_pkg::DIM_W-1:0] w_eff;
  logic [bbc_pkg::DIM_W-1:0] h_eff;
  logic [bbc_pkg::RAD_W-1:0] r_eff;
  logic [2:0]                nch_eff;

  logic [JOB_W-1:0] job_dout;
  logic [RES_W-1:0] res_dout;
  logic cfg_wr;
  logic cfg_settle;
  logic accept;
  logic job_push;
  logic job_pop;
  logic job_empty;
  logic job_full;
  logic res_push;
  logic res_full;
  logic back_busy;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign full      = !job_empty || back_busy || res_full || cfg_settle;
  assign accept    = push && !full;
  assign pix       = {chan3_in, chan2_in, chan1_in, chan0_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      win_side      <= 4'd3;
      frame_width   <= 11'd640;
      frame_height  <= 13'd480;
      channel_count <= 3'd3;
    end else if (cfg_wr) begin
      case (bbc_pkg::cfg_reg_t'(cfg_index))
        bbc_pkg::REG_KERNEL:   win_side <= cfg_data[3:0];
        bbc_pkg::REG_WIDTH:    frame_width <= cfg_data[10:0];
        bbc_pkg::REG_HEIGHT:   frame_height <= cfg_data[12:0];
        bbc_pkg::REG_CHANNELS: channel_count <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_settle <= 1'b1;
    end else begin
      cfg_settle <= cfg_wr;
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w_eff = bbc_pkg::DIM_W'(1);
    end else if (bbc_pkg::DIM_W'(frame_width) > bbc_pkg::DIM_W'(MAX_WIDTH)) begin
      w_eff = bbc_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = bbc_pkg::DIM_W'(frame_width);
    end
    h_eff = (frame_height == '0) ? bbc_pkg::DIM_W'(1) : frame_height;
    if (!win_side[0] || int'(win_side) > MAX_KERNEL) begin
      r_eff = '0;
    end else begin
      r_eff = win_side[3:1];
    end
    if (channel_count == '0) begin
      nch_eff = 3'd1;
    end else if (int'(channel_count) > MAX_CHANNELS) begin
      nch_eff = 3'(MAX_CHANNELS);
    end else begin
      nch_eff = channel_count;
    end
  end

  always_ff @(posedge clk) begin
    geom.w     <= w_eff;
    geom.h     <= h_eff;
    geom.r     <= r_eff;
    geom.nch   <= nch_eff;
    geom.total <= bbc_pkg::IDX_W'(w_eff) * bbc_pkg::IDX_W'(h_eff);
    geom.lag   <= bbc_pkg::IDX_W'(r_eff) * bbc_pkg::IDX_W'(w_eff)
                  + bbc_pkg::IDX_W'(r_eff);
  end

  bbc_front #(
    .ROWS(ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .restart  (cfg_wr),
    .accept   (accept),
    .mode     (mode),
    .pix      (pix),
    .wr       (wr),
    .job_push (job_push),
    .job      (job_in)
  );

  bbc_fifo #(
    .W(JOB_W),
    .DEPTH(2)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_dout),
    .empty (job_empty),
    .full  (job_full)
  );

  assign job_out = bbc_pkg::job_t'(job_dout);

  bbc_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .ROWS(ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .wr        (wr),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res_in),
    .busy      (back_busy)
  );

  bbc_fifo #(
    .W(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .pop   (pop && !empty),
    .dout  (res_dout),
    .empty (empty),
    .full  (res_full)
  );

  assign res_out   = bbc_pkg::result_t'(res_dout);
  assign chan0_out = res_out.chan[0];
  assign chan1_out = res_out.chan[1];
  assign chan2_out = res_out.chan[2];
  assign chan3_out = res_out.chan[3];
  assign frame_end = res_out.frame_end;

  `BBC_ASSERT_IMPL(a_job_room, clk, rst, job_push, !job_full)
endmodule
